FILE: src/assert_macros.svh
// Shared assertion macros for the list core checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, sampled on the rising edge, off during reset.
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/olar_pkg.sv
package olar_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic [1:0] mode_t;
    typedef logic [2:0] status_t;

    localparam mode_t MODE_APPEND = 2'd0;
    localparam mode_t MODE_REMOVE = 2'd1;
    localparam mode_t MODE_DUMP   = 2'd2;

    localparam status_t ST_APPENDED = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_REMOVED  = 3'd2;
    localparam status_t ST_NOTFOUND = 3'd3;
    localparam status_t ST_ENTRY    = 3'd4;
    localparam status_t ST_EMPTY    = 3'd5;

endpackage

FILE: src/olar_ram.sv
module olar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/ordered_list_append_remove_core.sv
// Ordered list core: up to DEPTH signed words kept in insertion order in one RAM.
// Append: result beat in the cycle after the command beat; a new command may be taken in that cycle if m_ready is high.
// Remove: one RAM read per entry, then the result beat once the output register is free.
// Dump: entry beats in list order, one entry beat per cycle while the output does not stall.
// Throughput is set by the single RAM read port; output stalls hold the sequencer.
// Reset (aresetn, synchronous, active low) empties the list; RAM contents are not cleared.
module ordered_list_append_remove_core
    import olar_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic signed [DATA_W-1:0] s_value,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic signed [DATA_W-1:0] m_entry_value,
    output logic                     m_last
);

    // Sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_RM_SCAN = 2'd1;
    localparam logic [1:0] S_RM_DONE = 2'd2;
    localparam logic [1:0] S_DUMP    = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;     // next address to read
    logic [IDX_W-1:0]  dat_idx_reg, dat_idx_next;   // address of the word on the RAM output
    logic              dat_vld_reg, dat_vld_next;   // RAM output holds an unconsumed word
    logic              found_reg, found_next;
    logic [DATA_W-1:0] op_value_reg, op_value_next;

    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [DATA_W-1:0] m_entry_value_reg;
    logic              m_last_reg;

    // RAM port signals
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    // Output register load
    logic              out_load;
    status_t           out_status;
    logic [DATA_W-1:0] out_value;
    logic              out_last;

    logic              out_free;
    logic              in_beat;
    logic              more_to_read;
    logic              dat_is_last;

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == S_IDLE) && out_free;
    assign in_beat      = s_valid && s_ready;
    assign more_to_read = rd_idx_reg < count_reg;
    assign dat_is_last  = (CNT_W'(dat_idx_reg) + CNT_W'(1)) == count_reg;

    olar_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        dat_idx_next  = dat_idx_reg;
        dat_vld_next  = dat_vld_reg;
        found_next    = found_reg;
        op_value_next = op_value_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[IDX_W-1:0];
        ram_wr_data = s_value;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_idx_reg[IDX_W-1:0];

        out_load   = 1'b0;
        out_status = ST_APPENDED;
        out_value  = s_value;
        out_last   = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    op_value_next = s_value;
                    rd_idx_next   = '0;
                    dat_vld_next  = 1'b0;
                    found_next    = 1'b0;
                    unique case (s_mode)
                        MODE_APPEND: begin
                            out_load = 1'b1;
                            if (count_reg < CNT_W'(DEPTH)) begin
                                // store at the tail
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                out_status = ST_FULL;
                            end
                        end
                        MODE_REMOVE: begin
                            if (count_reg == '0) begin
                                out_load   = 1'b1;
                                out_status = ST_NOTFOUND;
                            end else begin
                                state_next = S_RM_SCAN;
                            end
                        end
                        MODE_DUMP: begin
                            if (count_reg == '0) begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                                out_value  = '0;
                            end else begin
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            // unused mode: drop the beat
                        end
                    endcase
                end
            end

            S_RM_SCAN: begin
                // stream reads through the list, one address a cycle
                if (more_to_read) begin
                    ram_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    dat_idx_next = rd_idx_reg[IDX_W-1:0];
                    dat_vld_next = 1'b1;
                end else begin
                    dat_vld_next = 1'b0;
                end
                if (dat_vld_reg) begin
                    if (found_reg) begin
                        // close the gap: move this word down one place
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = dat_idx_reg - IDX_W'(1);
                        ram_wr_data = ram_rd_data;
                    end else if (ram_rd_data == op_value_reg) begin
                        found_next = 1'b1;
                    end
                    if (dat_is_last) begin
                        state_next = S_RM_DONE;
                    end
                end
            end

            S_RM_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_value  = op_value_reg;
                    out_status = found_reg ? ST_REMOVED : ST_NOTFOUND;
                    if (found_reg) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            S_DUMP: begin
                out_load   = dat_vld_reg && out_free;
                out_status = ST_ENTRY;
                out_value  = ram_rd_data;
                out_last   = dat_is_last;
                // advance the read only when the RAM output word is gone or leaving
                if (more_to_read && (!dat_vld_reg || out_load)) begin
                    ram_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    dat_idx_next = rd_idx_reg[IDX_W-1:0];
                    dat_vld_next = 1'b1;
                end else if (out_load) begin
                    dat_vld_next = 1'b0;
                end
                if (out_load && dat_is_last) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dat_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dat_vld_reg <= dat_vld_next;
            found_reg   <= found_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        dat_idx_reg  <= dat_idx_next;
        op_value_reg <= op_value_next;
        if (out_load) begin
            m_status_reg      <= out_status;
            m_entry_value_reg <= out_value;
            m_last_reg        <= out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_value = m_entry_value_reg;
    assign m_last        = m_last_reg;

endmodule

FILE: src/olar_checker.sv
`include "assert_macros.svh"

module olar_checker
    import olar_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [1:0]               s_mode,
    input logic signed [DATA_W-1:0] s_value,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [2:0]               m_status,
    input logic signed [DATA_W-1:0] m_entry_value,
    input logic                     m_last
);

    logic single_beat_status;
    logic [DATA_W+1:0] in_payload;
    logic [DATA_W+3:0] out_payload;

    assign single_beat_status = (m_status == ST_APPENDED) || (m_status == ST_FULL) ||
                                (m_status == ST_REMOVED) || (m_status == ST_NOTFOUND) ||
                                (m_status == ST_EMPTY);
    assign in_payload  = {s_mode, s_value};
    assign out_payload = {m_status, m_entry_value, m_last};

    // stalled command beat holds
    `AST_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(in_payload))

    // stalled result beat holds
    `AST_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_payload))

    // only defined status codes leave the block
    `AST_IMPL(a_status_code, aclk, aresetn, m_valid, m_status <= ST_EMPTY)

    // every result but a dump entry is the only beat of its command
    `AST_IMPL(a_single_last, aclk, aresetn, m_valid && single_beat_status, m_last)

    // an empty dump carries a zero value
    `AST_IMPL(a_empty_zero, aclk, aresetn, m_valid && (m_status == ST_EMPTY), m_entry_value == '0)

endmodule

bind ordered_list_append_remove_core olar_checker u_olar_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_mode        (s_mode),
    .s_value       (s_value),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_value (m_entry_value),
    .m_last        (m_last)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import olar_pkg::*;

    // Mode 3 has no meaning to the core: the beat must be swallowed without a result.
    localparam mode_t MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 4 * DEPTH + 40;
    localparam int RAND_PHASES  = 13;
    localparam int PHASE_ITEMS  = 30;

    // One result beat as the core presents it.
    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] entry_value;
        logic              last;
    } list_beat_t;

    // One row of the directed walk. Rows marked 'pinned' carry a hand-typed result
    // (always a single beat, last set); the others are left to the shadow list.
    typedef struct packed {
        mode_t             mode;
        logic [DATA_W-1:0] value;
        logic [4:0]        reps;
        logic              pinned;
        status_t           status;
        logic [DATA_W-1:0] exp_value;
    } dir_row_t;

    localparam int NDIR = 21;
    localparam dir_row_t DIRECTED [NDIR] = '{
        // empty list: dump gives one empty beat, remove misses
        '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,    32'h0000_0000},
        '{MODE_REMOVE, 32'h0000_0005, 5'd1,  1'b1, ST_NOTFOUND, 32'h0000_0005},
        '{MODE_UNUSED, 32'hFFFF_FFFF, 5'd1,  1'b0, ST_APPENDED, 32'h0000_0000},
        // extremes of the value range, plus a duplicate of the head
        '{MODE_APPEND, 32'h8000_0000, 5'd1,  1'b1, ST_APPENDED, 32'h8000_0000},
        '{MODE_APPEND, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_APPENDED, 32'h7FFF_FFFF},
        '{MODE_APPEND, 32'h0000_0000, 5'd1,  1'b1, ST_APPENDED, 32'h0000_0000},
        '{MODE_APPEND, 32'h8000_0000, 5'd1,  1'b1, ST_APPENDED, 32'h8000_0000},
        '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_APPENDED, 32'h0000_0000},
        // first match goes (head), then the later duplicate (tail), then a miss
        '{MODE_REMOVE, 32'h8000_0000, 5'd1,  1'b1, ST_REMOVED,  32'h8000_0000},
        '{MODE_REMOVE, 32'h8000_0000, 5'd1,  1'b1, ST_REMOVED,  32'h8000_0000},
        '{MODE_REMOVE, 32'h1234_5678, 5'd1,  1'b1, ST_NOTFOUND, 32'h1234_5678},
        '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_APPENDED, 32'h0000_0000},
        // fill to DEPTH, then overflow
        '{MODE_APPEND, 32'hA5A5_A5A5, 5'd14, 1'b1, ST_APPENDED, 32'hA5A5_A5A5},
        '{MODE_APPEND, 32'h0000_0001, 5'd1,  1'b1, ST_FULL,     32'h0000_0001},
        '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_APPENDED, 32'h0000_0000},
        // remove from the middle, refill, then the head of the full list, then the tail
        '{MODE_REMOVE, 32'hA5A5_A5A5, 5'd1,  1'b1, ST_REMOVED,  32'hA5A5_A5A5},
        '{MODE_APPEND, 32'h5A5A_5A5A, 5'd1,  1'b1, ST_APPENDED, 32'h5A5A_5A5A},
        '{MODE_REMOVE, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_REMOVED,  32'h7FFF_FFFF},
        '{MODE_REMOVE, 32'h5A5A_5A5A, 5'd1,  1'b1, ST_REMOVED,  32'h5A5A_5A5A},
        '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_APPENDED, 32'h0000_0000},
        '{MODE_UNUSED, 32'hFFFF_FFFF, 5'd1,  1'b0, ST_APPENDED, 32'h0000_0000}
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_mode;
    logic signed [DATA_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [2:0]               m_status;
    logic signed [DATA_W-1:0] m_entry_value;
    logic                     m_last;

    // Shadow copy of the list, head at index 0, and the beats still owed by the core.
    logic [DATA_W-1:0] shadow_list [$];
    list_beat_t        fresh_beats [$];
    list_beat_t        awaited_beats [$];

    int failures    = 0;
    int cycle_count = 0;
    int ready_hold  = 0;
    bit calm        = 1'b0;   // no idling on either side while set

    ordered_list_append_remove_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_last        (m_last)
    );

    // 4 ns period.
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Give up on a hang; the limit sits far beyond the slowest legal run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Apply one accepted command to the shadow list and work out the beats it owes.
    task automatic track_list_op(input mode_t mode, input logic [DATA_W-1:0] value);
        int hit;
        fresh_beats.delete();
        case (mode)
            MODE_APPEND: begin
                if (shadow_list.size() >= DEPTH) begin
                    fresh_beats.push_back('{ST_FULL, value, 1'b1});
                end else begin
                    shadow_list.push_back(value);
                    fresh_beats.push_back('{ST_APPENDED, value, 1'b1});
                end
            end
            MODE_REMOVE: begin
                hit = -1;
                for (int i = 0; i < shadow_list.size(); i++) begin
                    if (hit < 0 && shadow_list[i] == value) hit = i;
                end
                if (hit < 0) begin
                    fresh_beats.push_back('{ST_NOTFOUND, value, 1'b1});
                end else begin
                    shadow_list.delete(hit);
                    fresh_beats.push_back('{ST_REMOVED, value, 1'b1});
                end
            end
            MODE_DUMP: begin
                if (shadow_list.size() == 0) begin
                    fresh_beats.push_back('{ST_EMPTY, {DATA_W{1'b0}}, 1'b1});
                end else begin
                    for (int i = 0; i < shadow_list.size(); i++) begin
                        fresh_beats.push_back('{ST_ENTRY, shadow_list[i],
                                                i == shadow_list.size() - 1});
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Mostly back-to-back, now and then a short or a long hold-off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Drive one command beat from the falling edge and hold it until the core takes it.
    // Valid is only ever dropped here or in park_sender, never in the step that raises it.
    task automatic send_beat(input mode_t mode, input logic [DATA_W-1:0] value);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic park_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Send, then queue either the hand-typed result or the shadow list's prediction.
    task automatic issue(input mode_t mode, input logic [DATA_W-1:0] value,
                         input logic pinned, input status_t status,
                         input logic [DATA_W-1:0] exp_value);
        send_beat(mode, value);
        track_list_op(mode, value);
        if (pinned) begin
            awaited_beats.push_back('{status, exp_value, 1'b1});
        end else begin
            foreach (fresh_beats[i]) awaited_beats.push_back(fresh_beats[i]);
        end
    endtask

    // Operands: removes mostly aim at stored values so they hit; appends lean on a
    // small pool so that duplicates and first-match removal get exercised.
    function automatic logic [DATA_W-1:0] pick_operand(input mode_t mode);
        int r;
        r = $urandom_range(99);
        if (mode == MODE_REMOVE && shadow_list.size() > 0 && r < 55)
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        if (r < 80) return $urandom_range(0, 7) - 4;
        if (r < 88) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    // Result side: pick ready at the falling edge, in runs of random length.
    always @(negedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin : pick_stall
            int r;
            r = $urandom_range(99);
            if (r < 60) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end else if (r < 90) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else if (r < 98) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(3, 10);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(20, 60);
            end
        end
    end

    // Check every result beat against the oldest one owed.
    always @(posedge aclk) begin : check_beat
        list_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_beats.size() == 0) begin
                $error("result beat with nothing owed: status %0d entry_value %0d last %0b",
                       m_status, m_entry_value, m_last);
                failures++;
            end else begin
                want = awaited_beats.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failures++;
                end
                if (m_entry_value !== want.entry_value) begin
                    $error("entry_value: expected %0d, got %0d",
                           $signed(want.entry_value), m_entry_value);
                    failures++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_last);
                    failures++;
                end
            end
        end
    end

    initial begin : stimulus
        mode_t             mode;
        logic [DATA_W-1:0] value;
        int                append_pct;
        int                r;

        // Hold every input at a known value with reset low, then release reset at a falling edge.
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode  = MODE_APPEND;
        s_value = '0;
        m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed walk: empty list, extremes, duplicates, full list, mode 3.
        for (int row = 0; row < NDIR; row++) begin
            for (int k = 0; k < DIRECTED[row].reps; k++) begin
                issue(DIRECTED[row].mode, DIRECTED[row].value, DIRECTED[row].pinned,
                      DIRECTED[row].status, DIRECTED[row].exp_value);
            end
        end

        // Random phases rotate between growing the list towards full, a middle mix, and
        // draining it towards empty. Every fourth phase runs with no idling.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            calm = (phase % 4 == 3);
            case (phase % 3)
                0:       append_pct = 70;
                1:       append_pct = 45;
                default: append_pct = 25;
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Stray mode 3 beats come on top of the counted items.
                if ($urandom_range(99) < 3) issue(MODE_UNUSED, $urandom(), 1'b0, ST_EMPTY, '0);
                r = $urandom_range(99);
                if (r < 12)
                    mode = MODE_DUMP;
                else if (r < 12 + append_pct * 88 / 100)
                    mode = MODE_APPEND;
                else
                    mode = MODE_REMOVE;
                value = pick_operand(mode);
                issue(mode, value, 1'b0, ST_EMPTY, '0);
            end
            // Every other phase, hold the sender until the core has caught up.
            if (phase % 2 == 0) begin
                park_sender();
                while (awaited_beats.size() != 0) @(posedge aclk);
            end
        end

        park_sender();
        calm = 1'b0;
        while (awaited_beats.size() != 0) @(posedge aclk);
        // Leave room for any stray beat the core might still emit.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
